FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cau_pkg.sv
package cau_pkg;

    localparam int DW = 32;                  // bits per part
    localparam int FB = 16;                  // fraction bits
    localparam int PW = 2 * DW;              // product width
    localparam int MW = 2 * DW + 1;          // sum / magnitude width
    localparam int NW = MW + FB;             // scaled dividend width
    localparam int CW = (MW + DW > NW) ? MW + DW : NW;  // divider compare width

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                mode;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0] res_re;
        logic signed [DW-1:0] res_im;
        logic                 overflow;
        logic                 div_zero;
    } t_out;

endpackage

FILE: src/complex_arithmetic_unit_top.sv
// Complex add / subtract / multiply / divide, signed fixed point per part.
// Pipeline: 4 front stages, a range check, one restoring-divider stage per quotient bit,
// and the output register.
// Throughput: one beat per cycle; the whole pipe freezes only while a held result is stalled.
// Reset (i_rst_n low, synchronous) empties every stage; data registers are not cleared.
`include "assert_macros.svh"

module complex_arithmetic_unit_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cau_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cau_pkg::t_out o_out_data
);
    import cau_pkg::*;

    localparam logic [MW-1:0] HALF = MW'(1) << (DW - 1);
    localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};

    logic en;

    // stage 1: input register
    logic  r1_v;
    t_in   r1_d;
    // stage 2: products and add / sub
    logic                 r2_v, r2_bz;
    t_mode                r2_mode;
    logic signed [PW-1:0] r2_rr, r2_ii, r2_ir, r2_ri, r2_bb, r2_cc;
    logic signed [DW:0]   r2_sre, r2_sim;
    // stage 3: product sums
    logic                 r3_v, r3_bz;
    t_mode                r3_mode;
    logic signed [MW-1:0] r3_re, r3_im;
    logic [MW-1:0]        r3_den;
    // stage 4: sign and magnitude
    logic                 r4_v, r4_bz, r4_neg_re, r4_neg_im;
    t_mode                r4_mode;
    logic [MW-1:0]        r4_mag_re, r4_mag_im, r4_den;
    // divider stages 0..DW
    logic                 r_sv      [0:DW];
    logic                 r_sbz     [0:DW];
    t_mode                r_smode   [0:DW];
    logic                 r_sneg_re [0:DW];
    logic                 r_sneg_im [0:DW];
    logic                 r_sbig_re [0:DW];
    logic                 r_sbig_im [0:DW];
    logic [MW-1:0]        r_sden    [0:DW];
    logic [NW-1:0]        r_srem_re [0:DW];
    logic [NW-1:0]        r_srem_im [0:DW];
    logic [DW-1:0]        r_sq_re   [0:DW];
    logic [DW-1:0]        r_sq_im   [0:DW];
    // output register
    logic r_ov;
    t_out r_od;

    logic [MW-1:0] n4_mag_re, n4_mag_im;
    logic [NW-1:0] n5_num_re, n5_num_im;
    logic [CW:0]   n5_dif_re, n5_dif_im;
    logic          n5_div;
    t_out          n_od;

    // pipe advances unless a finished beat is held
    assign en          = !(r_ov && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_sv[0] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r_sv[0] <= r4_v;
            r_ov <= r_sv[DW];
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d <= i_in_data;
        end
    end

    // stage 2: six products, add / sub
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_mode <= r1_d.mode;
            r2_bz   <= (r1_d.b_re == '0) && (r1_d.b_im == '0);
            r2_rr   <= PW'(r1_d.a_re) * PW'(r1_d.b_re);
            r2_ii   <= PW'(r1_d.a_im) * PW'(r1_d.b_im);
            r2_ir   <= PW'(r1_d.a_im) * PW'(r1_d.b_re);
            r2_ri   <= PW'(r1_d.a_re) * PW'(r1_d.b_im);
            r2_bb   <= PW'(r1_d.b_re) * PW'(r1_d.b_re);
            r2_cc   <= PW'(r1_d.b_im) * PW'(r1_d.b_im);
            if (r1_d.mode == MODE_SUB) begin
                r2_sre <= (DW+1)'(r1_d.a_re) - (DW+1)'(r1_d.b_re);
                r2_sim <= (DW+1)'(r1_d.a_im) - (DW+1)'(r1_d.b_im);
            end else begin
                r2_sre <= (DW+1)'(r1_d.a_re) + (DW+1)'(r1_d.b_re);
                r2_sim <= (DW+1)'(r1_d.a_im) + (DW+1)'(r1_d.b_im);
            end
        end
    end

    // stage 3: product sums, divisor magnitude squared
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mode <= r2_mode;
            r3_bz   <= r2_bz;
            r3_den  <= MW'($unsigned(r2_bb)) + MW'($unsigned(r2_cc));
            case (r2_mode)
                MODE_MUL: begin
                    r3_re <= MW'(r2_rr) - MW'(r2_ii);
                    r3_im <= MW'(r2_ir) + MW'(r2_ri);
                end
                MODE_DIV: begin
                    r3_re <= MW'(r2_rr) + MW'(r2_ii);
                    r3_im <= MW'(r2_ir) - MW'(r2_ri);
                end
                default: begin
                    r3_re <= MW'(r2_sre);
                    r3_im <= MW'(r2_sim);
                end
            endcase
        end
    end

    // stage 4: magnitudes, product scaling truncates toward zero
    always_comb begin
        n4_mag_re = r3_re[MW-1] ? MW'(-r3_re) : MW'(r3_re);
        n4_mag_im = r3_im[MW-1] ? MW'(-r3_im) : MW'(r3_im);
        if (r3_mode == MODE_MUL) begin
            n4_mag_re = n4_mag_re >> FB;
            n4_mag_im = n4_mag_im >> FB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_mode   <= r3_mode;
            r4_bz     <= r3_bz;
            r4_den    <= r3_den;
            r4_neg_re <= r3_re[MW-1];
            r4_neg_im <= r3_im[MW-1];
            r4_mag_re <= n4_mag_re;
            r4_mag_im <= n4_mag_im;
        end
    end

    // divider stage 0: quotient range check against den << DW
    always_comb begin
        n5_div    = (r4_mode == MODE_DIV);
        n5_num_re = NW'(r4_mag_re) << FB;
        n5_num_im = NW'(r4_mag_im) << FB;
        n5_dif_re = {1'b0, CW'(n5_num_re)} - {1'b0, CW'(r4_den) << DW};
        n5_dif_im = {1'b0, CW'(n5_num_im)} - {1'b0, CW'(r4_den) << DW};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_smode[0]   <= r4_mode;
            r_sbz[0]     <= r4_bz;
            r_sden[0]    <= r4_den;
            r_sneg_re[0] <= r4_neg_re;
            r_sneg_im[0] <= r4_neg_im;
            r_sbig_re[0] <= n5_div && !n5_dif_re[CW];
            r_sbig_im[0] <= n5_div && !n5_dif_im[CW];
            r_srem_re[0] <= n5_div ? n5_num_re : NW'(r4_mag_re);
            r_srem_im[0] <= n5_div ? n5_num_im : NW'(r4_mag_im);
            r_sq_re[0]   <= '0;
            r_sq_im[0]   <= '0;
        end
    end

    // restoring divider: one quotient bit per stage, MSB first
    for (genvar s = 0; s < DW; s++) begin : g_step
        localparam int B = DW - 1 - s;
        logic [CW:0]   n_dif_re, n_dif_im;
        logic          n_div;
        logic [NW-1:0] n_rem_re, n_rem_im;
        logic [DW-1:0] n_q_re, n_q_im;

        always_comb begin
            n_div    = (r_smode[s] == MODE_DIV);
            n_dif_re = {1'b0, CW'(r_srem_re[s])} - {1'b0, CW'(r_sden[s]) << B};
            n_dif_im = {1'b0, CW'(r_srem_im[s])} - {1'b0, CW'(r_sden[s]) << B};
            n_rem_re = r_srem_re[s];
            n_rem_im = r_srem_im[s];
            n_q_re   = r_sq_re[s];
            n_q_im   = r_sq_im[s];
            if (n_div && !n_dif_re[CW]) begin
                n_rem_re  = n_dif_re[NW-1:0];
                n_q_re[B] = 1'b1;
            end
            if (n_div && !n_dif_im[CW]) begin
                n_rem_im  = n_dif_im[NW-1:0];
                n_q_im[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s+1] <= 1'b0;
            end else if (en) begin
                r_sv[s+1] <= r_sv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_smode[s+1]   <= r_smode[s];
                r_sbz[s+1]     <= r_sbz[s];
                r_sden[s+1]    <= r_sden[s];
                r_sneg_re[s+1] <= r_sneg_re[s];
                r_sneg_im[s+1] <= r_sneg_im[s];
                r_sbig_re[s+1] <= r_sbig_re[s];
                r_sbig_im[s+1] <= r_sbig_im[s];
                r_srem_re[s+1] <= n_rem_re;
                r_srem_im[s+1] <= n_rem_im;
                r_sq_re[s+1]   <= n_q_re;
                r_sq_im[s+1]   <= n_q_im;
            end
        end
    end

    // output: saturate, sign, zero divisor
    function automatic logic [DW:0] sat(input logic big, input logic [MW-1:0] m,
                                        input logic neg);
        logic ovf;
        logic [DW-1:0] v;
        ovf = neg ? (big || (m > HALF)) : (big || (m >= HALF));
        if (ovf) begin
            v = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            v = neg ? DW'(-m) : m[DW-1:0];
        end
        return {ovf, v};
    endfunction

    always_comb begin
        logic [DW:0]   s_re, s_im;
        logic [MW-1:0] m_re, m_im;
        if (r_smode[DW] == MODE_DIV) begin
            m_re = MW'(r_sq_re[DW]);
            m_im = MW'(r_sq_im[DW]);
        end else begin
            m_re = r_srem_re[DW][MW-1:0];
            m_im = r_srem_im[DW][MW-1:0];
        end
        s_re = sat(r_sbig_re[DW], m_re, r_sneg_re[DW]);
        s_im = sat(r_sbig_im[DW], m_im, r_sneg_im[DW]);
        n_od.res_re   = s_re[DW-1:0];
        n_od.res_im   = s_im[DW-1:0];
        n_od.overflow = s_re[DW] | s_im[DW];
        n_od.div_zero = 1'b0;
        if ((r_smode[DW] == MODE_DIV) && r_sbz[DW]) begin
            n_od = '0;
            n_od.div_zero = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_od <= n_od;
        end
    end

    // checks
    logic chk_busy, chk_dz_clr, chk_sat;
    assign chk_busy   = o_out_valid && i_out_stall;
    assign chk_dz_clr = (o_out_data.res_re == '0) && (o_out_data.res_im == '0)
                        && !o_out_data.overflow;
    assign chk_sat    = (o_out_data.res_re == SAT_POS) || (o_out_data.res_re == SAT_NEG)
                        || (o_out_data.res_im == SAT_POS) || (o_out_data.res_im == SAT_NEG);

    `CAU_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, chk_busy, "input stalled")
    `CAU_ASSERT_NOW(a_dz_zero, i_clk, i_rst_n, o_out_valid && o_out_data.div_zero, chk_dz_clr, "dz")
    `CAU_ASSERT_NOW(a_ovf_sat, i_clk, i_rst_n, o_out_valid && o_out_data.overflow, chk_sat, "ovf")

endmodule

FILE: tb/tb_complex_arithmetic_unit_top.sv
module tb_complex_arithmetic_unit_top;
    import cau_pkg::*;

    localparam int LATENCY   = 38;
    localparam int WDOG_MAX  = 5000;
    localparam int N_RANDOM  = 1200;
    localparam logic signed [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MAX_NEG = {1'b1, {(DW-1){1'b0}}};

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_stall;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_stall;
    t_out  o_out_data;

    complex_arithmetic_unit_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    t_in   pending_ops[$];
    t_out  expected_results[$];
    int    n_errors;
    int    idle_cycles;
    bit    hold_sender;
    bit    in_accepted;
    int    burst_left;
    int    gap_left;
    int    stall_phase;
    int    stall_period;

    // Clamp a wide signed value into a part; flags saturation
    function automatic logic signed [DW-1:0] clamp_part(input logic signed [191:0] v,
                                                        inout logic ovf);
        if (v > 192'sd2147483647) begin
            ovf = 1'b1;
            return MAX_POS;
        end else if (v < -192'sd2147483648) begin
            ovf = 1'b1;
            return MAX_NEG;
        end
        return v[DW-1:0];
    endfunction

    // Truncating (toward zero) arithmetic shift by the fraction bits
    function automatic logic signed [191:0] scale_down(input logic signed [191:0] v);
        logic signed [191:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> FB;
        return (v < 0) ? -m : m;
    endfunction

    // Expected complex result for one operand pair
    function automatic t_out complex_result(input t_in op);
        t_out r;
        logic ovf;
        logic signed [191:0] ar, ai, br, bi, re, im, den, nre, nim;
        ovf = 1'b0;
        ar = 192'(op.a_re);
        ai = 192'(op.a_im);
        br = 192'(op.b_re);
        bi = 192'(op.b_im);
        r = '0;
        case (op.mode)
            MODE_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            MODE_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            MODE_MUL: begin
                re = scale_down(ar * br - ai * bi);
                im = scale_down(ai * br + ar * bi);
            end
            default: begin
                if (br == 0 && bi == 0) begin
                    r.div_zero = 1'b1;
                    return r;
                end
                den = br * br + bi * bi;
                nre = (ar * br + ai * bi) <<< FB;
                nim = (ai * br - ar * bi) <<< FB;
                // SV signed division truncates toward zero
                re = nre / den;
                im = nim / den;
            end
        endcase
        r.res_re = clamp_part(re, ovf);
        r.res_im = clamp_part(im, ovf);
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic signed [DW-1:0] rand_part();
        case ($urandom_range(0, 7))
            0: return MAX_POS;
            1: return MAX_NEG;
            2: return 0;
            3: return $signed(32'($urandom_range(0, 4)) - 32'sd2);
            4: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
            5: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic t_in make_op(input t_mode m, input logic signed [DW-1:0] a_re,
                                    input logic signed [DW-1:0] a_im,
                                    input logic signed [DW-1:0] b_re,
                                    input logic signed [DW-1:0] b_im);
        t_in op;
        op.mode = m;
        op.a_re = a_re;
        op.a_im = a_im;
        op.b_re = b_re;
        op.b_im = b_im;
        return op;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: bursts with random gaps, changes on falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_accepted) begin
            // hold stalled beat
        end else begin
            if (in_accepted) begin
                void'(pending_ops.pop_front());
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (!hold_sender && pending_ops.size() > 0) begin
                i_in_data <= pending_ops[0];
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: periodic with a changing period, sometimes off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_phase = stall_phase + 1;
            if (stall_phase >= 64) begin
                stall_phase = 0;
                stall_period = $urandom_range(0, 5);
            end
            if (stall_period == 0) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= (stall_phase % (stall_period + 1)) == 0 ||
                               ($urandom_range(0, 9) == 0);
            end
        end
    end

    // Monitor: capture inputs, check outputs, watchdog
    always @(posedge i_clk) begin
        in_accepted = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (in_accepted) begin
                expected_results.push_back(complex_result(i_in_data));
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, o_out_data);
                    n_errors++;
                end else begin
                    t_out exp_r;
                    exp_r = expected_results.pop_front();
                    if (exp_r !== o_out_data) begin
                        $display("%0t: mismatch expected re=%0d im=%0d ovf=%b dz=%b",
                                 $time, exp_r.res_re, exp_r.res_im, exp_r.overflow,
                                 exp_r.div_zero);
                        $display("%0t:          actual   re=%0d im=%0d ovf=%b dz=%b",
                                 $time, o_out_data.res_re, o_out_data.res_im,
                                 o_out_data.overflow, o_out_data.div_zero);
                        n_errors++;
                    end
                end
            end
            if (in_accepted || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WDOG_MAX) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        t_mode m;
        int    k;
        n_errors = 0;
        idle_cycles = 0;
        hold_sender = 1'b0;
        in_accepted = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        stall_period = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_in_data = '0;

        // Directed: extremes, each mode, zero and tiny divisors
        for (int mi = 0; mi < 4; mi++) begin
            m = t_mode'(mi);
            pending_ops.push_back(make_op(m, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG));
            pending_ops.push_back(make_op(m, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG));
            pending_ops.push_back(make_op(m, 32'sh0001_0000, -32'sh0002_0000,
                                          32'sh0003_0000, 32'sh0000_8000));
        end
        pending_ops.push_back(make_op(MODE_DIV, 32'sh0001_0000, 32'sh0001_0000, 0, 0));
        pending_ops.push_back(make_op(MODE_DIV, 0, 0, 0, 0));
        pending_ops.push_back(make_op(MODE_DIV, MAX_POS, MAX_NEG, 1, 0));
        pending_ops.push_back(make_op(MODE_DIV, 32'sh0001_0000, 0, 0, -1));
        pending_ops.push_back(make_op(MODE_DIV, -32'sh0000_0003, 32'sh0000_0005,
                                      32'sh0002_0000, 0));
        pending_ops.push_back(make_op(MODE_MUL, -1, -1, -1, 1));
        pending_ops.push_back(make_op(MODE_MUL, 32'sh0100_0000, 0, 32'sh0100_0000, 0));
        pending_ops.push_back(make_op(MODE_ADD, 32'sh5555_5555, 32'shAAAA_AAAA,
                                      32'shAAAA_AAAA, 32'sh5555_5555));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Pause until the directed beats have all returned
        wait (pending_ops.size() == 0);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0);
        @(negedge i_clk);
        hold_sender = 1'b0;

        for (k = 0; k < N_RANDOM; k++) begin
            m = t_mode'($urandom_range(0, 3));
            if (m == MODE_DIV && $urandom_range(0, 19) == 0) begin
                pending_ops.push_back(make_op(m, rand_part(), rand_part(), 0, 0));
            end else begin
                pending_ops.push_back(make_op(m, rand_part(), rand_part(),
                                              rand_part(), rand_part()));
            end
        end

        wait (pending_ops.size() == 0);
        @(negedge i_clk);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/cau_pkg.sv
src/complex_arithmetic_unit_top.sv
tb/tb_complex_arithmetic_unit_top.sv
